>>> rtl/rpn_calc_pkg.sv
// ----------------------------------------------------------------------------
// rpn_calc_pkg
// Shared types and codes for the RPN stack calculator: beat payloads, token
// and status codes, stack word format and the per-cell shift control.
// ----------------------------------------------------------------------------
package rpn_calc_pkg;

   localparam int WORD_W = 48;   // signed Q31.16

   localparam logic [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // token codes
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_MUL    = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_FINISH = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [WORD_W-1:0] top_value;
      logic [4:0]               depth;
      logic                     finished;
   } rsp_type;

   // per-cell shift control: take the word from the cell above (push side)
   // or from the cell below (pop side)
   typedef struct packed {
      logic load_prev;
      logic load_next;
   } cell_ctrl_type;

endpackage

>>> rtl/rpn_calc_cell.sv
// ----------------------------------------------------------------------------
// rpn_calc_cell
// One stack entry. Holds a word and loads from either neighbor on a shift.
// ----------------------------------------------------------------------------
module rpn_calc_cell (
   input  logic                                clock,
   input  rpn_calc_pkg::cell_ctrl_type         ctrl,
   input  logic [rpn_calc_pkg::WORD_W-1:0]     prev_value,
   input  logic [rpn_calc_pkg::WORD_W-1:0]     next_value,
   output logic [rpn_calc_pkg::WORD_W-1:0]     value
);

   logic [rpn_calc_pkg::WORD_W-1:0] value_ff;
   logic [rpn_calc_pkg::WORD_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load_prev) begin
         value_in = prev_value;
      end else if (ctrl.load_next) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> rtl/rpn_calc_muldiv.sv
// ----------------------------------------------------------------------------
// rpn_calc_muldiv
// Bit-serial Q31.16 multiply (shift-add, 48 steps) and divide (restoring,
// 64 steps) on magnitudes, with sign fix-up and saturation at the end.
// ----------------------------------------------------------------------------
module rpn_calc_muldiv (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                is_div,
   input  logic [rpn_calc_pkg::WORD_W-1:0]     opa,
   input  logic [rpn_calc_pkg::WORD_W-1:0]     opb,
   output logic                                done,
   output logic [rpn_calc_pkg::WORD_W-1:0]     result
);

   localparam int W = rpn_calc_pkg::WORD_W;
   localparam logic [5:0] MUL_LAST = 6'd47;
   localparam logic [5:0] DIV_LAST = 6'd63;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          is_div_ff, is_div_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  opnd_ff, opnd_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [63:0]   low_ff, low_in;

   logic [W-1:0]  mag_a, mag_b;
   logic [W:0]    mul_sum;
   logic [W+1:0]  div_trial;
   logic          div_ge;
   logic [63:0]   mag;
   logic          mul_ovf;

   assign mag_a = opa[W-1] ? (W'(0) - opa) : opa;
   assign mag_b = opb[W-1] ? (W'(0) - opb) : opb;

   assign mul_sum   = {1'b0, acc_ff} + (low_ff[0] ? {1'b0, opnd_ff} : {(W+1){1'b0}});
   assign div_trial = {1'b0, acc_ff, low_ff[63]} - {2'b00, opnd_ff};
   assign div_ge    = !div_trial[W+1];

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      opnd_in   = opnd_ff;
      acc_in    = acc_ff;
      low_in    = low_ff;
      if (start) begin
         busy_in   = 1'b1;
         is_div_in = is_div;
         neg_in    = opa[W-1] ^ opb[W-1];
         acc_in    = '0;
         if (is_div) begin
            cnt_in  = DIV_LAST;
            opnd_in = mag_b;
            low_in  = {mag_a, 16'd0};
         end else begin
            cnt_in  = MUL_LAST;
            opnd_in = mag_a;
            low_in  = {16'd0, mag_b};
         end
      end else if (busy_ff) begin
         if (is_div_ff) begin
            acc_in = div_ge ? div_trial[W-1:0] : {acc_ff[W-2:0], low_ff[63]};
            low_in = {low_ff[62:0], div_ge};
         end else begin
            acc_in = mul_sum[W:1];
            low_in = {16'd0, mul_sum[0], low_ff[W-1:1]};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      opnd_ff   <= opnd_in;
      acc_ff    <= acc_in;
      low_ff    <= low_in;
   end

   // product bits [79:16] or the full quotient
   assign mag     = is_div_ff ? low_ff : {acc_ff[31:0], low_ff[W-1:16]};
   assign mul_ovf = !is_div_ff && (acc_ff[W-1:32] != '0);

   always_comb begin
      if (mul_ovf) begin
         result = neg_ff ? rpn_calc_pkg::Q_MIN : rpn_calc_pkg::Q_MAX;
      end else if (neg_ff) begin
         result = (mag[63:W-1] != '0) ? rpn_calc_pkg::Q_MIN : (W'(0) - mag[W-1:0]);
      end else begin
         result = (mag[63:W-1] != '0) ? rpn_calc_pkg::Q_MAX : mag[W-1:0];
      end
   end

   assign done = done_ff;

endmodule

>>> rtl/rpn_stack_calculator.sv
// Timing: push, add, subtract, finish and every error go from the req beat
// through the S_RESP state into the rsp register; multiply and divide first
// wait in S_CALC for the bit-serial multiply/divide unit (one bit per cycle).
// Flow: one token at a time; the next req beat is taken once the
// previous result sits in the rsp register.
// Reset: synchronous, clears stack depth and control; stack words hold junk.
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish evaluator over pre-parsed tokens on a Q31.16 stack built
// as a chain of shift cells, with a shared serial multiply/divide unit.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rpn_calc_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rpn_calc_pkg::rsp_type   rsp_data
);

   localparam int W  = rpn_calc_pkg::WORD_W;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,   // waiting for a token
      S_CALC = 3'b010,   // multiply/divide unit running
      S_RESP = 3'b100    // result ready to go into the rsp register
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [2:0]               status_ff, status_in;
   logic                     fin_ff, fin_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rpn_calc_pkg::rsp_type    rsp_ff, rsp_in;

   // cell chain: cell 0 is top of stack, cell 1 the entry under it
   logic [W-1:0]                 cell_q [STACK_DEPTH];
   logic [W-1:0]                 head_in;
   rpn_calc_pkg::cell_ctrl_type  head_ctrl, body_ctrl;

   logic          accept;
   logic          under;
   logic          full;
   logic [W-1:0]  top_q, sec_q;
   logic [W:0]    sum;
   logic [W-1:0]  sum_sat;

   logic          md_start;
   logic          md_is_div;
   logic          md_done;
   logic [W-1:0]  md_result;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign top_q = cell_q[0];
   assign sec_q = cell_q[1];
   assign under = (count_ff < CW'(2));
   assign full  = (count_ff == CW'(STACK_DEPTH));

   // add/subtract with one guard bit, clamp on sign disagreement
   assign sum = (req_data.op == rpn_calc_pkg::OP_SUB)
              ? ({sec_q[W-1], sec_q} - {top_q[W-1], top_q})
              : ({sec_q[W-1], sec_q} + {top_q[W-1], top_q});
   assign sum_sat = (sum[W] != sum[W-1])
                  ? (sum[W] ? rpn_calc_pkg::Q_MIN : rpn_calc_pkg::Q_MAX)
                  : sum[W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      head_in      = sum_sat;
      head_ctrl    = '0;
      body_ctrl    = '0;
      md_start     = 1'b0;
      md_is_div    = (req_data.op == rpn_calc_pkg::OP_DIV);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = rpn_calc_pkg::ST_OK;
               fin_in    = 1'b0;
               state_in  = S_RESP;
               case (req_data.op)
                  rpn_calc_pkg::OP_PUSH: begin
                     if (full) begin
                        status_in = rpn_calc_pkg::ST_FULL;
                     end else begin
                        // integer -> Q31.16
                        head_in             = {req_data.value, 16'd0};
                        head_ctrl.load_prev = 1'b1;
                        body_ctrl.load_prev = 1'b1;
                        count_in            = count_ff + CW'(1);
                     end
                  end
                  rpn_calc_pkg::OP_ADD, rpn_calc_pkg::OP_SUB: begin
                     if (under) begin
                        status_in = rpn_calc_pkg::ST_UNDERFLOW;
                     end else begin
                        head_ctrl.load_prev = 1'b1;
                        body_ctrl.load_next = 1'b1;
                        count_in            = count_ff - CW'(1);
                     end
                  end
                  rpn_calc_pkg::OP_MUL, rpn_calc_pkg::OP_DIV: begin
                     if (under) begin
                        status_in = rpn_calc_pkg::ST_UNDERFLOW;
                     end else if (md_is_div && (top_q == '0)) begin
                        status_in = rpn_calc_pkg::ST_DIV_ZERO;
                     end else begin
                        md_start = 1'b1;
                        state_in = S_CALC;
                     end
                  end
                  rpn_calc_pkg::OP_FINISH: begin
                     if (count_ff == '0) begin
                        status_in = rpn_calc_pkg::ST_EMPTY;
                     end else begin
                        // words stay put; cell 0 still holds the answer
                        count_in = '0;
                        fin_in   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CALC: begin
            if (md_done) begin
               head_in             = md_result;
               head_ctrl.load_prev = 1'b1;
               body_ctrl.load_next = 1'b1;
               count_in            = count_ff - CW'(1);
               state_in            = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.top_value = (fin_ff || (count_ff != '0)) ? top_q : '0;
               rsp_in.depth     = 5'(count_ff);
               rsp_in.finished  = fin_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         status_ff    <= rpn_calc_pkg::ST_OK;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stack cells; the bottom cell refills from itself on a pop
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [W-1:0] prev_v, next_v;
      if (i == 0) begin : g_head
         assign prev_v = head_in;
      end else begin : g_body
         assign prev_v = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign next_v = cell_q[i];
      end else begin : g_mid
         assign next_v = cell_q[i+1];
      end
      rpn_calc_cell u_cell (
         .clock      (clock),
         .ctrl       ((i == 0) ? head_ctrl : body_ctrl),
         .prev_value (prev_v),
         .next_value (next_v),
         .value      (cell_q[i])
      );
   end

   // operands: second entry op top entry
   rpn_calc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .is_div (md_is_div),
      .opa    (sec_q),
      .opb    (top_q),
      .done   (md_done),
      .result (md_result)
   );

endmodule
